// ===== rtl/pee_pkg.sv =====
// Shared types and constants for the postfix expression evaluator.
// No dependencies.
`timescale 1ns / 1ps
package pee_pkg;
  localparam int unsigned StackDepthDef = 128;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpMul = 2'd1,
    OpDiv = 2'd2,
    OpPow = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
    logic        dz;
  } alu_rsp_t;
endpackage

// ===== rtl/pee_if.sv =====
// Valid/ready channel interfaces for the evaluator.
// Depends on nothing.
`timescale 1ns / 1ps
interface pee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;
  modport source (output valid, symbol, last, input ready);
  modport sink (input valid, symbol, last, output ready);
endinterface

interface pee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               divide_by_zero;
  modport source (output valid, value, divide_by_zero, input ready);
  modport sink (input valid, value, divide_by_zero, output ready);
endinterface

// ===== rtl/postfix_expression_evaluator_top.sv =====
// Postfix evaluator: one ASCII character per item, result on the last item.
// A new item is taken only once the last is done; a non-digit first pushes a pending number.
// Operators pop their operands and run on the ALU: divide takes 32 divider steps, power steps
// through the exponent bits with multiply and square. The last item pushes, reads and emits the top.
// A result waits in the output register; the next item may be taken meanwhile. Reset clears
// count, accumulator and flags asynchronously; stack memory is never cleared.
`timescale 1ns / 1ps
module postfix_expression_evaluator_top #(
  parameter int unsigned STACK_DEPTH = pee_pkg::StackDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  pee_in_if.sink    in_i,
  pee_out_if.source out_o
);
  import pee_pkg::*;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [8:0] {
    SIdle  = 9'b000000001,
    SPush  = 9'b000000010,  // push pending number then dispatch symbol
    SSym   = 9'b000000100,  // dispatch symbol
    SPopB  = 9'b000001000,  // issue read of top
    SPopA  = 9'b000010000,  // capture b, issue read of next
    SExec  = 9'b000100000,  // capture a, start ALU
    SWait  = 9'b001000000,  // wait for ALU
    SFin   = 9'b010000000,  // push pending number at end
    SOut   = 9'b100000000   // read top, emit
  } state_e;

  state_e      state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic        innum_q, innum_d;
  logic        dz_q, dz_d;
  logic [7:0]  sym_q, sym_d;
  logic        last_q, last_d;
  logic        after_q, after_d;   // item followed a digit
  logic        unary_q, unary_d;
  logic        hasb_q, hasb_d, hasa_q, hasa_d;
  logic [31:0] b_q, b_d, a_q, a_d;
  logic        ovld_q, ovld_d;
  logic [31:0] oval_q, oval_d;
  logic        odz_q, odz_d;
  logic        fin_q, fin_d;       // output read pending

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  alu_req_t      req;
  alu_rsp_t      rsp;
  logic          is_digit, is_letter, is_op;

  pee_stack #(.Depth(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );
  pee_alu u_alu (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  always_comb begin
    is_digit  = sym_q >= ChZero && sym_q <= ChNine;
    is_letter = (sym_q >= ChLowerA && sym_q <= 8'h7A) || (sym_q >= 8'h41 && sym_q <= 8'h5A);
    is_op     = sym_q == ChMinus || sym_q == ChPlus || sym_q == ChStar ||
                sym_q == ChSlash || sym_q == ChCaret;
  end

  // push helper: write at count when not full
  function automatic logic can_push(input logic [CW-1:0] c);
    can_push = c < CW'(STACK_DEPTH);
  endfunction

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; acc_d = acc_q; innum_d = innum_q; dz_d = dz_q;
    sym_d = sym_q; last_d = last_q; after_d = after_q; unary_d = unary_q;
    hasb_d = hasb_q; hasa_d = hasa_q; b_d = b_q; a_d = a_q;
    ovld_d = ovld_q; oval_d = oval_q; odz_d = odz_q; fin_d = 1'b0;
    we = 1'b0; waddr = cnt_q[AW-1:0]; wdata = acc_q;
    raddr = cnt_q[AW-1:0] - AW'(1);
    req = '{start: 1'b0, op: OpAdd, a: a_q, b: b_q};
    in_i.ready = 1'b0;
    if (out_o.ready) ovld_d = 1'b0;
    if (fin_q) begin
      // emit top read last cycle, then clear evaluation state
      oval_d = (cnt_q != '0) ? rdata : 32'd0; odz_d = dz_q; ovld_d = 1'b1;
      cnt_d = '0; acc_d = '0; innum_d = 1'b0; dz_d = 1'b0;
    end
    case (state_q)
      SIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          sym_d = in_i.symbol; last_d = in_i.last; after_d = innum_q;
          state_d = SSym;
          if (!(in_i.symbol >= ChZero && in_i.symbol <= ChNine) && innum_q) state_d = SPush;
        end
      end
      SPush: begin
        if (can_push(cnt_q)) begin
          we = 1'b1; cnt_d = cnt_q + CW'(1);
        end
        acc_d = '0; innum_d = 1'b0; state_d = SSym;
      end
      SSym: begin
        state_d = last_q ? SFin : SIdle;
        if (is_digit) begin
          acc_d = 32'(acc_q * 32'd10) + {28'd0, 4'(sym_q - ChZero)};
          innum_d = 1'b1;
        end else if (is_letter) begin
          we = can_push(cnt_q); wdata = {24'd0, sym_q} - 32'd96;
          if (we) cnt_d = cnt_q + CW'(1);
        end else if (is_op) begin
          unary_d = sym_q == ChMinus && after_q;
          state_d = SPopB;
        end
      end
      SPopB: begin
        // read top is in flight (raddr = cnt-1)
        hasb_d = cnt_q != '0;
        if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
        state_d = SPopA;
      end
      SPopA: begin
        b_d = hasb_q ? rdata : 32'd0;
        hasa_d = cnt_q != '0;
        if (!unary_q && cnt_q != '0) cnt_d = cnt_q - CW'(1);
        state_d = SExec;
      end
      SExec: begin
        a_d = (hasa_q && !unary_q) ? rdata : 32'd0;
        req.start = 1'b1;
        req.a = unary_q ? 32'd0 : a_d;
        case (sym_q)
          ChPlus:  req.op = OpAdd;
          ChStar:  req.op = OpMul;
          ChSlash: req.op = OpDiv;
          ChCaret: req.op = OpPow;
          default: begin
            req.op = OpAdd; req.b = 32'd0 - b_q;
          end
        endcase
        state_d = SWait;
      end
      SWait: begin
        if (rsp.done) begin
          if (rsp.dz) dz_d = 1'b1;
          we = can_push(cnt_q); wdata = rsp.res;
          if (we) cnt_d = cnt_q + CW'(1);
          state_d = last_q ? SFin : SIdle;
        end
      end
      SFin: begin
        if (innum_q && can_push(cnt_q)) begin
          we = 1'b1; cnt_d = cnt_q + CW'(1);
        end
        innum_d = 1'b0;
        state_d = SOut;
      end
      SOut: begin
        if (!ovld_q || out_o.ready) begin
          fin_d = 1'b1; state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
    // SIdle after SOut: hold input until emit done
    if (fin_q) in_i.ready = 1'b0;
    if (fin_q && state_q == SIdle) state_d = SIdle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; cnt_q <= '0; acc_q <= '0; innum_q <= 1'b0; dz_q <= 1'b0;
      ovld_q <= 1'b0; fin_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; acc_q <= acc_d; innum_q <= innum_d;
      dz_q <= dz_d; ovld_q <= ovld_d; fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d; last_q <= last_d; after_q <= after_d; unary_q <= unary_d;
    hasb_q <= hasb_d; hasa_q <= hasa_d; b_q <= b_d; a_q <= a_d;
    oval_q <= oval_d; odz_q <= odz_d;
  end

  assign out_o.valid = ovld_q;
  assign out_o.value = oval_q;
  assign out_o.divide_by_zero = odz_q;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !in_i.ready) else $error("item taken while busy");
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> (cnt_q == '0 && !dz_q && ovld_q)) else $error("emit did not reset state");
`endif
endmodule

// ===== rtl/pee_alu.sv =====
// Multi-cycle arithmetic unit: add, multiply, radix-2 divide, square-and-multiply power.
// Depends on pee_pkg.
`timescale 1ns / 1ps
module pee_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pee_pkg::alu_req_t req_i,
  output pee_pkg::alu_rsp_t rsp_o
);
  import pee_pkg::*;

  logic        busy_q, busy_d;
  alu_op_e     op_q, op_d;
  logic [31:0] x_q, x_d;   // divisor magnitude / base
  logic [31:0] y_q, y_d;   // quotient-remainder work / exponent
  logic [31:0] r_q, r_d;   // remainder / result
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic        done_q, done_d;
  logic        dz_q, dz_d;
  logic        phase_q, phase_d;  // power: 0 multiply result, 1 square base
  logic [31:0] ma, mb;
  logic [32:0] rem_sh;

  always_comb begin
    ma = req_i.a[31] ? 32'd0 - req_i.a : req_i.a;
    mb = req_i.b[31] ? 32'd0 - req_i.b : req_i.b;
    rem_sh = {r_q, y_q[31]};
    busy_d = busy_q; op_d = op_q; x_d = x_q; y_d = y_q; r_d = r_q;
    cnt_d = cnt_q; neg_d = neg_q; done_d = 1'b0; dz_d = 1'b0; phase_d = phase_q;
    if (req_i.start) begin
      op_d = req_i.op;
      case (req_i.op)
        OpAdd: begin
          r_d = req_i.a + req_i.b; done_d = 1'b1;
        end
        OpMul: begin
          r_d = req_i.a * req_i.b; done_d = 1'b1;
        end
        OpDiv: begin
          if (req_i.b == 32'd0) begin
            r_d = 32'd0; dz_d = 1'b1; done_d = 1'b1;
          end else begin
            x_d = mb; y_d = ma; r_d = 32'd0; cnt_d = 6'd32;
            neg_d = req_i.a[31] ^ req_i.b[31]; busy_d = 1'b1;
          end
        end
        default: begin
          if (req_i.b[31] || req_i.b == 32'd0) begin
            r_d = 32'd1; done_d = 1'b1;
          end else begin
            x_d = req_i.a; y_d = req_i.b; r_d = 32'd1; phase_d = 1'b0; busy_d = 1'b1;
          end
        end
      endcase
    end else if (busy_q) begin
      if (op_q == OpDiv) begin
        // shift one quotient bit into y, remainder in r
        if (rem_sh >= {1'b0, x_q}) begin
          r_d = 32'(rem_sh - {1'b0, x_q}); y_d = {y_q[30:0], 1'b1};
        end else begin
          r_d = rem_sh[31:0]; y_d = {y_q[30:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_d = 1'b0; done_d = 1'b1;
          r_d = neg_q ? 32'd0 - y_d : y_d;
        end
      end else begin
        if (!phase_q) begin
          if (y_q[0]) r_d = r_q * x_q;
          phase_d = 1'b1;
          if (y_q[31:1] == 31'd0) begin
            busy_d = 1'b0; done_d = 1'b1;
          end
        end else begin
          x_d = x_q * x_q; y_d = {1'b0, y_q[31:1]}; phase_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; dz_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; dz_q <= dz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; x_q <= x_d; y_q <= y_d; r_q <= r_d;
    cnt_q <= cnt_d; neg_q <= neg_d; phase_q <= phase_d;
  end

  assign rsp_o = '{done: done_q, res: r_q, dz: dz_q};
endmodule

// ===== rtl/pee_stack.sv =====
// Operand stack memory: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module pee_stack #(
  parameter int unsigned Depth = 128,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);
  logic [31:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the postfix expression evaluator: directed and random expressions,
// each result checked against a predictor that evaluates every character as it is accepted.
// Depends on pee_pkg, pee_if.sv and postfix_expression_evaluator_top.
`timescale 1ns / 1ps
module tb;
  import pee_pkg::*;

  localparam int unsigned Depth = StackDepthDef;
  localparam int unsigned DrainCycles = 120;   // longer than the slowest power operation

  typedef struct packed {
    logic signed [31:0] value;
    logic               dz;
  } total_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pee_in_if  sym_ch ();
  pee_out_if tot_ch ();

  postfix_expression_evaluator_top #(.STACK_DEPTH(Depth)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sym_ch.sink),
    .out_o  (tot_ch.source)
  );

  always #6 clk_i = ~clk_i;

  // Generous: every item at the slowest operation plus the longest stalls, many times over.
  initial begin
    #60ms;
    $display("tb NOT OK");
    $finish;
  end

  // Predictor state: a shadow of the evaluator.
  logic [31:0] shadow_stack [Depth];
  int unsigned shadow_count;
  logic [31:0] shadow_acc;
  bit          shadow_in_number;
  bit          shadow_dz;

  total_t expected_totals [$];
  int unsigned mismatches;
  int unsigned send_idle_pct, recv_stall_pct;
  byte unsigned expr_chars [$];

  function automatic void shadow_clear();
    shadow_count = 0;
    shadow_acc = '0;
    shadow_in_number = 1'b0;
    shadow_dz = 1'b0;
  endfunction

  function automatic void shadow_push(logic [31:0] v);
    if (shadow_count < Depth) begin
      shadow_stack[shadow_count] = v;
      shadow_count++;
    end
  endfunction

  function automatic logic [31:0] shadow_pop();
    if (shadow_count == 0) return '0;
    shadow_count--;
    return shadow_stack[shadow_count];
  endfunction

  function automatic logic [31:0] trunc_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    if (b == '0) begin
      shadow_dz = 1'b1;
      return '0;
    end
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] wrapped_power(logic [31:0] base, logic [31:0] ex);
    logic [31:0] r;
    r = 32'd1;
    if (ex[31] || ex == '0) return 32'd1;
    while (ex != '0) begin
      if (ex[0]) r = r * base;
      base = base * base;
      ex = ex >> 1;
    end
    return r;
  endfunction

  // Evaluate one accepted character; queue the total on the final one.
  function automatic void eval_symbol(logic [7:0] c, bit fin);
    bit after_digit;
    logic [31:0] a, b, r;
    total_t t;
    after_digit = shadow_in_number;
    if (c >= ChZero && c <= ChNine) begin
      shadow_acc = shadow_acc * 32'd10 + 32'(c - ChZero);
      shadow_in_number = 1'b1;
    end else begin
      if (shadow_in_number) begin
        shadow_push(shadow_acc);
        shadow_acc = '0;
        shadow_in_number = 1'b0;
      end
      if ((c >= ChLowerA && c <= "z") || (c >= "A" && c <= "Z")) begin
        shadow_push(32'(c) - 32'd96);
      end else if (c == ChMinus) begin
        if (after_digit) begin
          shadow_push(-shadow_pop());
        end else begin
          b = shadow_pop();
          a = shadow_pop();
          shadow_push(a - b);
        end
      end else if (c == ChPlus || c == ChStar || c == ChSlash || c == ChCaret) begin
        b = shadow_pop();
        a = shadow_pop();
        case (c)
          ChPlus:  r = a + b;
          ChStar:  r = a * b;
          ChSlash: r = trunc_quotient(a, b);
          default: r = wrapped_power(a, b);
        endcase
        shadow_push(r);
      end
    end
    if (fin) begin
      if (shadow_in_number) shadow_push(shadow_acc);
      t.value = shadow_pop();
      t.dz = shadow_dz;
      expected_totals.push_back(t);
      shadow_clear();
    end
  endfunction

  // Present one item; valid stays high into the next call unless that call idles first.
  task automatic send_item(byte unsigned s, bit fin);
    while ($urandom_range(99) < send_idle_pct) begin
      sym_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    sym_ch.valid  <= 1'b1;
    sym_ch.symbol <= s;
    sym_ch.last   <= fin;
    do @(posedge clk_i); while (!sym_ch.ready);
    eval_symbol(s, fin);
    @(negedge clk_i);
  endtask

  // Send the queued characters as one expression, last on the final character.
  task automatic send_expr();
    foreach (expr_chars[i]) send_item(expr_chars[i], i == expr_chars.size() - 1);
    expr_chars.delete();
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
    send_expr();
  endtask

  // Hold the sender until every total has come back, then let the block settle.
  task automatic drain();
    sym_ch.valid <= 1'b0;
    while (expected_totals.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Receiver: stall at random on the falling edge.
  always @(negedge clk_i) tot_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  // Compare each accepted total with the oldest expectation.
  always @(posedge clk_i) begin
    total_t want;
    if (rst_ni && tot_ch.valid && tot_ch.ready) begin
      if (expected_totals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected total value=%0d dz=%0b", tot_ch.value, tot_ch.divide_by_zero);
      end else begin
        want = expected_totals.pop_front();
        if (tot_ch.value !== want.value || tot_ch.divide_by_zero !== want.dz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("total mismatch: expected value=%0d dz=%0b, got value=%0d dz=%0b",
                     want.value, want.dz, tot_ch.value, tot_ch.divide_by_zero);
        end
      end
    end
  end

  // Field extremes, every operator and the awkward arithmetic corners.
  task automatic test_directed();
    send_string("2147483647 1+");        // wraps to INT_MIN
    send_string("4294967297");           // accumulator wraps to 1
    send_string("7 0/ 3+");              // divide by zero sets the flag
    send_string("2147483648 1-/");       // INT_MIN / -1 via unary minus
    send_string("7 2-/");                // negative divisor truncates
    send_string("3 0^ 2 5 1-^* 3 31^+"); // zero and negative exponents, wrapping power
    send_string("Za*");                  // upper case letter is negative
    send_string("-");                    // binary minus on an empty stack
    send_string(" ");                    // nothing pushed
    send_string("12");                   // number still pending at the end
    send_string({8'hFF, "9", 8'h80, "5 6*"});
  endtask

  // Fill past the top of the stack; extra pushes are dropped.
  task automatic test_stack_full();
    for (int i = 0; i < Depth + 3; i++) expr_chars.push_back(8'("a" + (i % 26)));
    expr_chars.push_back("+");
    send_expr();
  endtask

  task automatic push_number();
    int unsigned n;
    n = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(3, 1);
    for (int i = 0; i < n; i++) expr_chars.push_back(8'(ChZero + $urandom_range(9)));
  endtask

  // Well-formed expressions with random content, some noise and broken ones mixed in.
  task automatic test_random(int unsigned items);
    int unsigned sent, depth, kind;
    bit prev_digit;
    byte unsigned ops [4];
    ops = '{ChPlus, ChStar, ChSlash, ChCaret};
    sent = 0;
    while (sent < items) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        repeat ($urandom_range(6, 1)) expr_chars.push_back(8'($urandom_range(255)));
      end else begin
        depth = 0;
        prev_digit = 1'b0;
        repeat ($urandom_range(8, 2)) begin
          if (depth >= 2 && $urandom_range(2) == 0) begin
            if (prev_digit && $urandom_range(3) != 0) expr_chars.push_back(" ");
            if ($urandom_range(4) == 0) expr_chars.push_back(ChMinus);
            else expr_chars.push_back(ops[$urandom_range(3)]);
            depth--;
            prev_digit = 1'b0;
          end else begin
            if (prev_digit) expr_chars.push_back(" ");
            if ($urandom_range(3) == 0) begin
              expr_chars.push_back($urandom_range(1) ? 8'("a" + $urandom_range(25))
                                                     : 8'("A" + $urandom_range(25)));
              prev_digit = 1'b0;
            end else begin
              push_number();
              prev_digit = 1'b1;
              if ($urandom_range(5) == 0) expr_chars.push_back(ChMinus);  // unary
            end
            depth++;
          end
        end
        // Broken tail: an operator too many now and then.
        if (kind < 22) expr_chars.push_back(ops[$urandom_range(3)]);
      end
      sent += expr_chars.size();
      send_expr();
    end
  endtask

  initial begin
    mismatches = 0;
    shadow_clear();
    send_idle_pct = 6;
    recv_stall_pct = 56;
    sym_ch.valid = 1'b0;
    sym_ch.symbol = '0;
    sym_ch.last = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    drain();                  // sender holds until every total is back
    test_stack_full();
    test_random(290);
    send_idle_pct = 56;
    recv_stall_pct = 6;
    test_random(290);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(290);
    drain();

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
